FILE: hw/rtl/lpr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// Depends on nothing; every other file of the block imports it.
package lpr_pkg;

    // Fixed port widths of the block
    localparam int CFG_W        = 4;
    localparam int PAGE_PORT_W  = 16;
    localparam int FRAME_PORT_W = 3;
    localparam int COUNT_W      = 32;

    // Reset value of the frames-in-use register
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SWEEP
    } t_state;

    // Strobes from the sequencer to the frame memory
    typedef struct packed {
        logic rd_en;
        logic page_we;
        logic rank_we;
    } t_mem_ctl;

endpackage

FILE: hw/rtl/lpr_frame_mem.sv
// Frame memory: page number and recency rank of each frame, one read and
// one write port each, registered read data. Depends on lpr_pkg.
module lpr_frame_mem #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int IW        = 3
) (
    input  logic                  i_clk,
    input  lpr_pkg::t_mem_ctl     i_ctl,
    input  logic [IW-1:0]         i_rd_addr,
    input  logic [IW-1:0]         i_wr_addr,
    input  logic [PAGE_BITS-1:0]  i_wr_page,
    input  logic [IW-1:0]         i_wr_rank,
    output logic [PAGE_BITS-1:0]  o_rd_page,
    output logic [IW-1:0]         o_rd_rank
);
    import lpr_pkg::*;

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [IW-1:0]        rank_mem [FRAMES];
    logic [PAGE_BITS-1:0] r_rd_page;
    logic [IW-1:0]        r_rd_rank;

    // Write page and rank entries
    always_ff @(posedge i_clk) begin
        if (i_ctl.page_we) begin
            page_mem[i_wr_addr] <= i_wr_page;
        end
        if (i_ctl.rank_we) begin
            rank_mem[i_wr_addr] <= i_wr_rank;
        end
    end

    // Read both stores at one address, data valid the next cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_page <= page_mem[i_rd_addr];
            r_rd_rank <= rank_mem[i_rd_addr];
        end
    end

    assign o_rd_page = r_rd_page;
    assign o_rd_rank = r_rd_rank;

endmodule

FILE: hw/rtl/lpr_ctrl.sv
// Sequencer of the LRU page replacement block: scans the active frames,
// picks hit, empty or oldest frame, sweeps ranks on a hit or eviction and issues the result.
// Depends on lpr_pkg; drives lpr_frame_mem.
module lpr_ctrl #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int IW        = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [lpr_pkg::PAGE_PORT_W-1:0]    i_page_number,
    input  logic [lpr_pkg::CFG_W-1:0]          i_frames_cfg,
    output lpr_pkg::t_mem_ctl                  o_mem_ctl,
    output logic [IW-1:0]                      o_rd_addr,
    output logic [IW-1:0]                      o_wr_addr,
    output logic [PAGE_BITS-1:0]               o_wr_page,
    output logic [IW-1:0]                      o_wr_rank,
    input  logic [PAGE_BITS-1:0]               i_rd_page,
    input  logic [IW-1:0]                      i_rd_rank,
    output logic                               o_done,
    output logic                               o_was_hit,
    output logic [lpr_pkg::FRAME_PORT_W-1:0]   o_frame_used,
    output logic                               o_did_evict,
    output logic [lpr_pkg::PAGE_PORT_W-1:0]    o_evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]        o_fault_total
);
    import lpr_pkg::*;

    localparam int CW = $clog2(FRAMES + 1);

    // Control state
    t_state               r_state, n_state;
    logic                 r_chk_vld, n_chk_vld;
    logic [FRAMES-1:0]    r_valid, n_valid;
    logic [CW-1:0]        r_valid_cnt, n_valid_cnt;
    logic [COUNT_W-1:0]   r_fault_cnt, n_fault_cnt;
    logic                 r_done, n_done;

    // Per-item working registers
    logic [PAGE_BITS-1:0] r_page, n_page;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_rd_cnt, n_rd_cnt;
    logic [IW-1:0]        r_chk_idx, n_chk_idx;
    logic                 r_hit, n_hit;
    logic [IW-1:0]        r_hit_idx, n_hit_idx;
    logic [IW-1:0]        r_hit_rank, n_hit_rank;
    logic                 r_empty_fnd, n_empty_fnd;
    logic [IW-1:0]        r_empty_idx, n_empty_idx;
    logic                 r_min_fnd, n_min_fnd;
    logic [IW-1:0]        r_min_idx, n_min_idx;
    logic [IW-1:0]        r_min_rank, n_min_rank;
    logic [PAGE_BITS-1:0] r_min_page, n_min_page;
    logic [IW-1:0]        r_f, n_f;
    logic [IW-1:0]        r_r, n_r;

    // Result registers
    logic                    r_out_hit, n_out_hit;
    logic [FRAME_PORT_W-1:0] r_out_frame, n_out_frame;
    logic                    r_out_evict, n_out_evict;
    logic [PAGE_PORT_W-1:0]  r_out_evpage, n_out_evpage;

    // Combinational helpers
    logic                          issue;
    logic [IW-1:0]                 sel_f;
    logic [CW-1:0]                 cnt_m1;
    logic [PAGE_BITS+PAGE_PORT_W-1:0] page_in_wide;
    logic [PAGE_BITS+PAGE_PORT_W-1:0] page_out_wide;
    logic [IW+FRAME_PORT_W-1:0]    f_wide;

    assign page_in_wide  = {{PAGE_BITS{1'b0}}, i_page_number};
    assign page_out_wide = {{PAGE_PORT_W{1'b0}}, r_min_page};
    assign sel_f         = r_hit ? r_hit_idx : (r_empty_fnd ? r_empty_idx : r_min_idx);
    assign f_wide        = {{FRAME_PORT_W{1'b0}}, sel_f};
    assign cnt_m1        = r_valid_cnt - CW'(1);

    // Next state, memory strobes and result capture
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_valid_cnt  = r_valid_cnt;
        n_fault_cnt  = r_fault_cnt;
        n_done       = 1'b0;
        n_page       = r_page;
        n_n          = r_n;
        n_rd_cnt     = r_rd_cnt;
        n_chk_idx    = r_rd_cnt[IW-1:0];
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_rank   = r_hit_rank;
        n_empty_fnd  = r_empty_fnd;
        n_empty_idx  = r_empty_idx;
        n_min_fnd    = r_min_fnd;
        n_min_idx    = r_min_idx;
        n_min_rank   = r_min_rank;
        n_min_page   = r_min_page;
        n_f          = r_f;
        n_r          = r_r;
        n_out_hit    = r_out_hit;
        n_out_frame  = r_out_frame;
        n_out_evict  = r_out_evict;
        n_out_evpage = r_out_evpage;
        issue        = 1'b0;
        o_mem_ctl    = '0;
        o_wr_addr    = r_chk_idx;
        o_wr_page    = r_page;
        o_wr_rank    = '0;

        unique case (r_state)
            S_IDLE: begin
                // Take the beat, clamp the frame count
                if (start) begin
                    n_page      = page_in_wide[PAGE_BITS-1:0];
                    if (i_frames_cfg == '0) begin
                        n_n = CW'(1);
                    end else if (int'(i_frames_cfg) > FRAMES) begin
                        n_n = CW'(FRAMES);
                    end else begin
                        n_n = CW'(i_frames_cfg);
                    end
                    n_rd_cnt    = '0;
                    n_hit       = 1'b0;
                    n_empty_fnd = 1'b0;
                    n_min_fnd   = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // Read the next active frame while checking the previous one
                issue = (r_rd_cnt < r_n);
                if (issue) begin
                    n_rd_cnt = r_rd_cnt + CW'(1);
                end
                if (r_chk_vld) begin
                    if (!r_hit && r_valid[r_chk_idx] && (i_rd_page == r_page)) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_chk_idx;
                        n_hit_rank = i_rd_rank;
                    end
                    if (!r_empty_fnd && !r_valid[r_chk_idx]) begin
                        n_empty_fnd = 1'b1;
                        n_empty_idx = r_chk_idx;
                    end
                    if (!r_min_fnd || (i_rd_rank < r_min_rank)) begin
                        n_min_fnd  = 1'b1;
                        n_min_idx  = r_chk_idx;
                        n_min_rank = i_rd_rank;
                        n_min_page = i_rd_page;
                    end
                    if (!issue) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                // Pick the frame, latch the result fields, store the page on a fault
                n_f          = sel_f;
                n_r          = r_hit ? r_hit_rank : r_min_rank;
                n_out_hit    = r_hit;
                n_out_frame  = f_wide[FRAME_PORT_W-1:0];
                n_out_evict  = !r_hit && !r_empty_fnd;
                n_out_evpage = (!r_hit && !r_empty_fnd) ? page_out_wide[PAGE_PORT_W-1:0] : '0;
                o_wr_addr    = sel_f;
                if (!r_hit) begin
                    o_mem_ctl.page_we = 1'b1;
                    if (r_fault_cnt != '1) begin
                        n_fault_cnt = r_fault_cnt + COUNT_W'(1);
                    end
                end
                if (!r_hit && r_empty_fnd) begin
                    // Empty frame: it joins as the newest, no other rank moves
                    o_mem_ctl.rank_we = 1'b1;
                    o_wr_rank         = r_valid_cnt[IW-1:0];
                    n_valid[sel_f]    = 1'b1;
                    n_valid_cnt       = r_valid_cnt + CW'(1);
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_rd_cnt = '0;
                    n_state  = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // Read every frame's rank, write back the shifted one
                issue = (r_rd_cnt < CW'(FRAMES));
                if (issue) begin
                    n_rd_cnt = r_rd_cnt + CW'(1);
                end
                if (r_chk_vld) begin
                    if (r_chk_idx == r_f) begin
                        o_mem_ctl.rank_we = 1'b1;
                        o_wr_rank         = cnt_m1[IW-1:0];
                    end else if (r_valid[r_chk_idx] && (i_rd_rank > r_r)) begin
                        o_mem_ctl.rank_we = 1'b1;
                        o_wr_rank         = i_rd_rank - IW'(1);
                    end
                    if (!issue) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_mem_ctl.rd_en = issue;
        n_chk_vld       = issue;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_vld   <= 1'b0;
            r_valid     <= '0;
            r_valid_cnt <= '0;
            r_fault_cnt <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_vld   <= n_chk_vld;
            r_valid     <= n_valid;
            r_valid_cnt <= n_valid_cnt;
            r_fault_cnt <= n_fault_cnt;
            r_done      <= n_done;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_page       <= n_page;
        r_n          <= n_n;
        r_rd_cnt     <= n_rd_cnt;
        r_chk_idx    <= n_chk_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_rank   <= n_hit_rank;
        r_empty_fnd  <= n_empty_fnd;
        r_empty_idx  <= n_empty_idx;
        r_min_fnd    <= n_min_fnd;
        r_min_idx    <= n_min_idx;
        r_min_rank   <= n_min_rank;
        r_min_page   <= n_min_page;
        r_f          <= n_f;
        r_r          <= n_r;
        r_out_hit    <= n_out_hit;
        r_out_frame  <= n_out_frame;
        r_out_evict  <= n_out_evict;
        r_out_evpage <= n_out_evpage;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_rd_addr      = r_rd_cnt[IW-1:0];
    assign o_done         = r_done;
    assign o_was_hit      = r_out_hit;
    assign o_frame_used   = r_out_frame;
    assign o_did_evict    = r_out_evict;
    assign o_evicted_page = r_out_evpage;
    assign o_fault_total  = r_fault_cnt;

endmodule

FILE: hw/rtl/lru_page_replacement.sv
// LRU page replacement: one page reference per start beat, one result beat
// marked by o_done. An item scans the n active frames, where n is the clamped
// frame count (1..FRAMES), and ends there when it fills an empty frame; a hit
// or an eviction adds a rank sweep over all FRAMES entries. The single read
// port of the frame memory sets this: the scan reads one active frame a cycle.
// busy is low in the cycle o_done is high, so the next start may land there.
// The result is shown for that one cycle only; the receiver cannot stall it.
// Depends on lpr_pkg, lpr_frame_mem and lpr_ctrl.
module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [lpr_pkg::PAGE_PORT_W-1:0]    i_page_number,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                               o_done,
    output logic                               o_was_hit,
    output logic [lpr_pkg::FRAME_PORT_W-1:0]   o_frame_used,
    output logic                               o_did_evict,
    output logic [lpr_pkg::PAGE_PORT_W-1:0]    o_evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]        o_fault_total
);
    import lpr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [CFG_W-1:0]     r_frames_cfg;
    t_mem_ctl             mem_ctl;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        wr_addr;
    logic [PAGE_BITS-1:0] wr_page;
    logic [IW-1:0]        wr_rank;
    logic [PAGE_BITS-1:0] rd_page;
    logic [IW-1:0]        rd_rank;

    // Hold the frames-in-use register, written on any cfg beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_frames_cfg <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    lpr_frame_mem #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IW        (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_page (wr_page),
        .i_wr_rank (wr_rank),
        .o_rd_page (rd_page),
        .o_rd_rank (rd_rank)
    );

    lpr_ctrl #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IW        (IW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_page_number  (i_page_number),
        .i_frames_cfg   (r_frames_cfg),
        .o_mem_ctl      (mem_ctl),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_wr_page      (wr_page),
        .o_wr_rank      (wr_rank),
        .i_rd_page      (rd_page),
        .i_rd_rank      (rd_rank),
        .o_done         (o_done),
        .o_was_hit      (o_was_hit),
        .o_frame_used   (o_frame_used),
        .o_did_evict    (o_did_evict),
        .o_evicted_page (o_evicted_page),
        .o_fault_total  (o_fault_total)
    );

`ifndef NO_ASSERTIONS
    // An accepted beat makes the block busy on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted start did not raise busy");

    // A result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    // An eviction is always a fault
    a_evict_is_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_did_evict) |-> !o_was_hit)
        else $error("eviction reported on a hit");

    // A fault result carries a nonzero fault total
    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_was_hit) |-> (o_fault_total != '0))
        else $error("fault not counted");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for lru_page_replacement: drives page references and
// frame-count writes, predicts each result and compares it field by field.
// Depends on lpr_pkg and the lru_page_replacement RTL.
`timescale 1ns / 100ps

module tb;
    import lpr_pkg::*;

    localparam int FRAMES      = 8;
    localparam int PAGE_BITS   = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 24;

    typedef enum logic {
        OP_PAGE,
        OP_FRAMES
    } t_op_kind;

    typedef struct {
        t_op_kind           kind;
        logic [15:0]        value;
        int                 idle_pct;
    } t_stim_op;

    typedef struct {
        logic [PAGE_PORT_W-1:0]  page;
        logic                    was_hit;
        logic [FRAME_PORT_W-1:0] frame;
        logic                    did_evict;
        logic [PAGE_PORT_W-1:0]  evicted_page;
        logic [COUNT_W-1:0]      fault_total;
    } t_page_outcome;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [PAGE_PORT_W-1:0]  i_page_number = '0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    o_done;
    logic                    o_was_hit;
    logic [FRAME_PORT_W-1:0] o_frame_used;
    logic                    o_did_evict;
    logic [PAGE_PORT_W-1:0]  o_evicted_page;
    logic [COUNT_W-1:0]      o_fault_total;

    // Mirror of the frame table, kept in step with accepted beats
    logic [PAGE_PORT_W-1:0]  held_page [FRAMES];
    logic                    held_valid[FRAMES];
    logic [2:0]              held_rank [FRAMES];
    logic [COUNT_W-1:0]      fault_tally = '0;
    logic [CFG_W-1:0]        frames_setting = CFG_RESET;

    t_stim_op       stim_ops[$];
    t_page_outcome  page_outcomes[$];
    int             pages_sent = 0;
    int             pages_done = 0;
    int             frame_writes = 0;
    int             hit_count = 0;
    int             evict_count = 0;
    int             mismatches = 0;

    lru_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_page_number  (i_page_number),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_was_hit      (o_was_hit),
        .o_frame_used   (o_frame_used),
        .o_did_evict    (o_did_evict),
        .o_evicted_page (o_evicted_page),
        .o_fault_total  (o_fault_total)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        foreach (held_valid[i]) held_valid[i] = 1'b0;
    end

    // Clamp the register the way the block reads it: 0 acts as 1, above FRAMES as FRAMES
    function automatic int active_frames(input logic [CFG_W-1:0] setting);
        int n;
        n = int'(setting);
        if (n == 0) n = 1;
        if (n > FRAMES) n = FRAMES;
        return n;
    endfunction

    // Look up one page reference and advance the mirrored frame table
    function automatic t_page_outcome lru_lookup(input logic [PAGE_PORT_W-1:0] page);
        t_page_outcome o;
        int n, f, i, vcount, old_rank;
        logic hit, found;
        logic [2:0] best;
        n = active_frames(frames_setting);
        f = 0;
        hit = 1'b0;
        found = 1'b0;
        o.page = page;
        o.did_evict = 1'b0;
        o.evicted_page = '0;
        // search the active frames for the page
        for (i = 0; i < n; i++) begin
            if (!hit && held_valid[i] && held_page[i] == page) begin
                f = i;
                hit = 1'b1;
            end
        end
        if (!hit) begin
            // fill the first empty active frame, else evict the oldest active one
            for (i = 0; i < n; i++) begin
                if (!found && !held_valid[i]) begin
                    f = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                best = held_rank[0];
                for (i = 1; i < n; i++) begin
                    if (held_rank[i] < best) begin
                        best = held_rank[i];
                        f = i;
                    end
                end
                o.did_evict = 1'b1;
                o.evicted_page = held_page[f];
            end
            held_page[f] = page;
            if (fault_tally != '1) fault_tally++;
        end
        // promote frame f to most recent; ranks span every valid frame
        vcount = 0;
        for (i = 0; i < FRAMES; i++) if (held_valid[i]) vcount++;
        if (held_valid[f]) begin
            old_rank = int'(held_rank[f]);
            for (i = 0; i < FRAMES; i++) begin
                if (i != f && held_valid[i] && int'(held_rank[i]) > old_rank)
                    held_rank[i] = held_rank[i] - 3'd1;
            end
            held_rank[f] = 3'(vcount - 1);
        end else begin
            held_rank[f] = 3'(vcount);
            held_valid[f] = 1'b1;
        end
        o.was_hit = hit;
        o.frame = FRAME_PORT_W'(f);
        o.fault_total = fault_tally;
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] page,
                                        input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: page %0d %s expected %0d got %0d", $time, page, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_page(input logic [15:0] page, input int pct);
        stim_ops.push_back('{kind: OP_PAGE, value: page, idle_pct: pct});
    endtask

    task automatic push_frames(input int setting);
        stim_ops.push_back('{kind: OP_FRAMES, value: 16'(setting), idle_pct: 0});
    endtask

    // Driver: retire accepted beats, then launch the next pending op
    always @(posedge i_clk) begin : driver
        logic               next_start;
        logic               next_cfg_valid;
        logic [15:0]        next_page;
        logic [CFG_W-1:0]   next_cfg;
        t_stim_op           op;
        next_start = start;
        next_cfg_valid = i_cfg_valid;
        next_page = i_page_number;
        next_cfg = i_cfg_data;
        if (i_rst_n) begin
            if (start && !busy) begin
                page_outcomes.push_back(lru_lookup(i_page_number));
                pages_sent++;
                next_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                frames_setting = i_cfg_data;
                frame_writes++;
                next_cfg_valid = 1'b0;
            end
            if (!next_start && !next_cfg_valid && stim_ops.size() != 0) begin
                op = stim_ops[0];
                if (op.kind == OP_FRAMES) begin
                    // write the register only once every result is back
                    if (pages_sent == pages_done) begin
                        next_cfg_valid = 1'b1;
                        next_cfg = op.value[CFG_W-1:0];
                        void'(stim_ops.pop_front());
                    end
                end else if ($urandom_range(99) >= op.idle_pct) begin
                    next_start = 1'b1;
                    next_page = op.value;
                    void'(stim_ops.pop_front());
                end
            end
        end
        start <= next_start;
        i_page_number <= next_page;
        i_cfg_valid <= next_cfg_valid;
        i_cfg_data <= next_cfg;
    end

    // Monitor: compare each result beat against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_page_outcome want;
        if (i_rst_n && o_done) begin
            if (page_outcomes.size() == 0) begin
                $display("%0t: result beat with no reference outstanding, frame %0d",
                         $time, o_frame_used);
                mismatches++;
            end else begin
                want = page_outcomes.pop_front();
                check_field("was_hit", want.page, 32'(want.was_hit), 32'(o_was_hit));
                check_field("frame_used", want.page, 32'(want.frame), 32'(o_frame_used));
                check_field("did_evict", want.page, 32'(want.did_evict), 32'(o_did_evict));
                check_field("evicted_page", want.page, 32'(want.evicted_page),
                            32'(o_evicted_page));
                check_field("fault_total", want.page, want.fault_total, o_fault_total);
                hit_count += int'(want.was_hit);
                evict_count += int'(want.did_evict);
                pages_done <= pages_done + 1;
            end
        end
    end

    // Abort when no beat of any kind moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_done)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("lru_page_replacement regression: fail");
        $finish;
    end

    initial begin : stimulus
        int idle_modes[3] = '{22, 77, 0};
        int frame_choices[5] = '{1, 8, 4, 15, 0};
        int setting, span;
        logic [15:0] base;
        logic [15:0] pg;

        // Directed: reset setting of 8, extreme pages, hit, fill, eviction
        push_page(16'h0000, 22);
        push_page(16'hFFFF, 22);
        push_page(16'h0000, 22);
        for (int p = 1; p <= 6; p++) push_page(16'(p), 22);
        push_page(16'd7, 22);
        push_page(16'hFFFF, 22);
        // Shrink to two frames: outer frames stay resident but unseen
        push_frames(2);
        push_page(16'd3, 22);
        push_page(16'h8000, 22);
        // Zero behaves as one frame
        push_frames(0);
        push_page(16'h1234, 22);
        push_page(16'h1234, 22);
        push_page(16'h4321, 22);
        // Fifteen behaves as all frames; earlier pages become visible again
        push_frames(15);
        push_page(16'd5, 22);
        push_page(16'd4, 22);
        push_page(16'hAAAA, 22);
        push_page(16'h5555, 22);
        // Saturation of the fault total lies far beyond any practical run length

        // Random: working-set references with random noise, per idle mode and setting
        foreach (idle_modes[m]) begin
            for (int c = 0; c < 6; c++) begin
                setting = (c < 5) ? frame_choices[c] : $urandom_range(15);
                push_frames(setting);
                base = 16'($urandom_range(65535));
                span = active_frames(4'(setting)) + $urandom_range(3);
                repeat (58) begin
                    if ($urandom_range(99) < 70)
                        pg = base + 16'($urandom_range(span - 1));
                    else
                        pg = 16'($urandom_range(65535));
                    push_page(pg, idle_modes[m]);
                end
            end
        end

        // Hold reset, then let the driver run
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all ops launched and every result back
        while (stim_ops.size() != 0 || start || i_cfg_valid || pages_sent != pages_done)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d page references: %0d hits, %0d evictions, %0d frame-count writes",
                 pages_sent, hit_count, evict_count, frame_writes);
        $display("settings 0, 1, 4, 8, 15 and random, under three sender idle rates");
        if (mismatches == 0)
            $display("lru_page_replacement regression: pass");
        else
            $display("lru_page_replacement regression: fail");
        $finish;
    end

endmodule
